// ----- sv/tmpg_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and color functions for the text mode pixel generator
package tmpg_pkg;

   localparam int GLYPH_COUNT  = 128;
   localparam int CELL_COLUMNS = 32;
   localparam int CELL_ROWS    = 12;
   localparam int BORDER_WIDTH = 16;
   localparam int CELL_W       = 4;
   localparam int CELL_H       = 8;

   localparam int COORD_W = 10;
   localparam logic [COORD_W-1:0] TEXT_X_LO = COORD_W'(BORDER_WIDTH);
   localparam logic [COORD_W-1:0] TEXT_X_HI = COORD_W'(BORDER_WIDTH + CELL_COLUMNS * CELL_W);
   localparam logic [COORD_W-1:0] TEXT_Y_LO = COORD_W'(BORDER_WIDTH);
   localparam logic [COORD_W-1:0] TEXT_Y_HI = COORD_W'(BORDER_WIDTH + CELL_ROWS * CELL_H);

   localparam int PAL_DEPTH     = 16;
   localparam int PAL_IDX_W     = 4;
   localparam int PAL_W         = 12;
   localparam int GLYPH_DEPTH   = 256;
   localparam int GLYPH_ADDR_W  = 8;
   localparam int GLYPH_W       = 16;
   localparam int GLYPH_FIELD_W = 7;
   localparam int COLOR_W       = 24;
   localparam int CSR_DATA_W    = 4;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [7:0] CH_HI   = 8'd170;
   localparam logic [7:0] CH_STEP = 8'd85;
   localparam logic [PAL_IDX_W-1:0] IDX_BROWN = 4'd6;

   typedef enum logic [1:0] {
      MODE_PALETTE = 2'd0,
      MODE_GLYPH   = 2'd1,
      MODE_RENDER  = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_USE_LOADED   = 2'd0,
      CSR_BORDER_INDEX = 2'd1,
      CSR_BLINK_PHASE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                 use_loaded;
      logic [PAL_IDX_W-1:0] border_idx;
      logic                 blink_phase;
   } cfg_type;

   typedef struct packed {
      logic                 pal_load;
      logic                 glyph_load;
      logic                 render;
      logic                 border;
      logic                 cx_odd;
      logic [2:0]           cy;
      logic                 blink;
      logic [PAL_IDX_W-1:0] fg_idx;
      logic [PAL_IDX_W-1:0] bg_idx;
   } decode_type;

   typedef logic [GLYPH_FIELD_W-1:0] glyph_wrap_type [2**GLYPH_FIELD_W];

   function automatic glyph_wrap_type make_glyph_wrap();
      glyph_wrap_type t;
      for (int i = 0; i < 2**GLYPH_FIELD_W; i++) begin
         t[i] = GLYPH_FIELD_W'(i % GLYPH_COUNT);
      end
      return t;
   endfunction

   localparam glyph_wrap_type GLYPH_WRAP = make_glyph_wrap();

   function automatic logic [COLOR_W-1:0] default_color(input logic [PAL_IDX_W-1:0] idx);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r = idx[2] ? CH_HI : 8'd0;
      g = idx[1] ? CH_HI : 8'd0;
      b = idx[0] ? CH_HI : 8'd0;
      if (idx == IDX_BROWN) begin
         g = g - CH_STEP;
      end else if (idx[3]) begin
         r = r + CH_STEP;
         g = g + CH_STEP;
         b = b + CH_STEP;
      end
      return {r, g, b};
   endfunction

   // each nibble times 17 is the nibble repeated
   function automatic logic [COLOR_W-1:0] loaded_color(input logic [PAL_W-1:0] w);
      return {w[11:8], w[11:8], w[7:4], w[7:4], w[3:0], w[3:0]};
   endfunction

endpackage

// ----- sv/tmpg_ram.sv -----
`timescale 1ns / 1ps
// generic single write port ram with registered read
module tmpg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/tmpg_csr.sv -----
`timescale 1ns / 1ps
// configuration register file
module tmpg_csr import tmpg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_USE_LOADED:   cfg_in.use_loaded  = csr_data[0];
            CSR_BORDER_INDEX: cfg_in.border_idx  = csr_data[PAL_IDX_W-1:0];
            CSR_BLINK_PHASE:  cfg_in.blink_phase = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/tmpg_decode.sv -----
`timescale 1ns / 1ps
// input item decode: mode, border test, cell position and store addresses
module tmpg_decode import tmpg_pkg::*; (
   input  logic [1:0]              req_mode,
   input  logic [7:0]              req_store_index,
   input  logic [15:0]             req_data_word,
   input  logic [7:0]              req_pixel_x,
   input  logic [6:0]              req_pixel_y,
   input  cfg_type                 cfg,
   output decode_type              dec,
   output logic [GLYPH_ADDR_W-1:0] glyph_rd_addr
);

   logic [COORD_W-1:0]       x_ext;
   logic [COORD_W-1:0]       y_ext;
   logic [COORD_W-1:0]       dx;
   logic [COORD_W-1:0]       dy;
   logic                     border;
   logic [GLYPH_FIELD_W-1:0] glyph;

   assign x_ext  = COORD_W'(req_pixel_x);
   assign y_ext  = COORD_W'(req_pixel_y);
   assign dx     = x_ext - TEXT_X_LO;
   assign dy     = y_ext - TEXT_Y_LO;
   assign border = (x_ext < TEXT_X_LO) || (x_ext >= TEXT_X_HI) ||
                   (y_ext < TEXT_Y_LO) || (y_ext >= TEXT_Y_HI);

   // two glyph words per glyph, one per column pair
   assign glyph         = GLYPH_WRAP[req_data_word[GLYPH_FIELD_W-1:0]];
   assign glyph_rd_addr = {glyph, dx[1]};

   always_comb begin
      dec            = '0;
      dec.border     = border;
      dec.cx_odd     = dx[0];
      dec.cy         = dy[2:0];
      dec.blink      = req_data_word[7] & cfg.blink_phase;
      dec.fg_idx     = border ? cfg.border_idx : req_data_word[15:12];
      dec.bg_idx     = req_data_word[11:8];
      unique case (mode_type'(req_mode))
         MODE_PALETTE: dec.pal_load   = (req_store_index[7:PAL_IDX_W] == '0);
         MODE_GLYPH:   dec.glyph_load = 1'b1;
         MODE_RENDER:  dec.render     = 1'b1;
         default:      dec.render     = 1'b0;
      endcase
   end

endmodule

// ----- sv/tmpg_color.sv -----
`timescale 1ns / 1ps
// color selection and result register
module tmpg_color import tmpg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               s1_valid,
   input  decode_type         s1_dec,
   input  cfg_type            cfg,
   input  logic [PAL_W-1:0]   pal_fg_data,
   input  logic [PAL_W-1:0]   pal_bg_data,
   input  logic [GLYPH_W-1:0] glyph_data,
   output logic               rsp_valid,
   output logic [23:0]        rsp_pixel_color,
   output logic               rsp_in_border
);

   logic [COLOR_W-1:0] fg_color;
   logic [COLOR_W-1:0] bg_color;
   logic [COLOR_W-1:0] fg_shown;
   logic [7:0]         row_bits;
   logic               pixel_on;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [COLOR_W-1:0] rsp_color_ff;
   logic [COLOR_W-1:0] rsp_color_in;
   logic               rsp_border_ff;
   logic               rsp_border_in;

   assign fg_color = cfg.use_loaded ? loaded_color(pal_fg_data) : default_color(s1_dec.fg_idx);
   assign bg_color = cfg.use_loaded ? loaded_color(pal_bg_data) : default_color(s1_dec.bg_idx);
   assign fg_shown = s1_dec.blink ? bg_color : fg_color;

   // even columns use the high byte, odd columns the low byte
   assign row_bits = s1_dec.cx_odd ? glyph_data[7:0] : glyph_data[15:8];
   assign pixel_on = row_bits[s1_dec.cy];

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_border_in = rsp_border_ff;
      if (advance) begin
         rsp_valid_in  = s1_valid;
         rsp_border_in = s1_dec.border;
         if (s1_dec.border) begin
            rsp_color_in = fg_color;
         end else begin
            rsp_color_in = pixel_on ? fg_shown : bg_color;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_color_ff  <= rsp_color_in;
      rsp_border_ff <= rsp_border_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_in_border   = rsp_border_ff;

endmodule

// ----- sv/text_mode_pixel_generator.sv -----
`timescale 1ns / 1ps
// text mode pixel generator top level
// a render transfer is registered in the s1 decode register and the ram read registers, then in the result register
// throughput: one item per cycle, set by the registered read of the glyph and palette rams
// the whole pipeline holds while a result waits under rsp_stall
// load items write the stores in the cycle of acceptance and give no result
// reset clears the configuration registers and valid flags; store contents stay undefined
module text_mode_pixel_generator import tmpg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_mode,
   input  logic [7:0]             req_store_index,
   input  logic [15:0]            req_data_word,
   input  logic [7:0]             req_pixel_x,
   input  logic [6:0]             req_pixel_y,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [23:0]            rsp_pixel_color,
   output logic                   rsp_in_border,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type                 cfg;
   decode_type              dec;
   logic [GLYPH_ADDR_W-1:0] glyph_rd_addr;
   logic                    advance;
   logic                    accept;

   decode_type              s1_dec_ff;
   decode_type              s1_dec_in;
   logic                    s1_valid_ff;
   logic                    s1_valid_in;

   logic [PAL_W-1:0]        pal_fg_data;
   logic [PAL_W-1:0]        pal_bg_data;
   logic [GLYPH_W-1:0]      glyph_data;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   tmpg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tmpg_decode u_decode (
      .req_mode        (req_mode),
      .req_store_index (req_store_index),
      .req_data_word   (req_data_word),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .cfg             (cfg),
      .dec             (dec),
      .glyph_rd_addr   (glyph_rd_addr)
   );

   // two palette copies give the foreground and background reads in the same cycle
   tmpg_ram #(.WIDTH(PAL_W), .DEPTH(PAL_DEPTH)) u_pal_fg (
      .clock   (clock),
      .wr_en   (accept && dec.pal_load),
      .wr_addr (req_store_index[PAL_IDX_W-1:0]),
      .wr_data (req_data_word[PAL_W-1:0]),
      .rd_en   (advance),
      .rd_addr (dec.fg_idx),
      .rd_data (pal_fg_data)
   );

   tmpg_ram #(.WIDTH(PAL_W), .DEPTH(PAL_DEPTH)) u_pal_bg (
      .clock   (clock),
      .wr_en   (accept && dec.pal_load),
      .wr_addr (req_store_index[PAL_IDX_W-1:0]),
      .wr_data (req_data_word[PAL_W-1:0]),
      .rd_en   (advance),
      .rd_addr (dec.bg_idx),
      .rd_data (pal_bg_data)
   );

   tmpg_ram #(.WIDTH(GLYPH_W), .DEPTH(GLYPH_DEPTH)) u_glyph (
      .clock   (clock),
      .wr_en   (accept && dec.glyph_load),
      .wr_addr (req_store_index),
      .wr_data (req_data_word),
      .rd_en   (advance),
      .rd_addr (glyph_rd_addr),
      .rd_data (glyph_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_dec_in   = s1_dec_ff;
      if (advance) begin
         s1_valid_in = req_valid && dec.render;
         s1_dec_in   = dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_dec_ff <= s1_dec_in;
   end

   tmpg_color u_color (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .s1_valid        (s1_valid_ff),
      .s1_dec          (s1_dec_ff),
      .cfg             (cfg),
      .pal_fg_data     (pal_fg_data),
      .pal_bg_data     (pal_bg_data),
      .glyph_data      (glyph_data),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_in_border   (rsp_in_border)
   );

endmodule

// ----- sv/tmpg_checker.sv -----
`timescale 1ns / 1ps
// port level checks for the text mode pixel generator, bound to the top level
module tmpg_checker import tmpg_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [23:0] rsp_pixel_color,
   input logic        rsp_in_border
);

   // a held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_color) && $stable(rsp_in_border))
      else $error("result changed while stalled");

   // input stalls only behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with free result register");

   // a render transfer reaches the output register when it is not held
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_mode == MODE_RENDER) ##1 !rsp_stall |=> rsp_valid)
      else $error("render transfer gave no result");

   // a load or unused mode transfer gives no result
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_mode != MODE_RENDER) ##1 !rsp_stall |=> !rsp_valid)
      else $error("non render transfer gave a result");

endmodule

bind text_mode_pixel_generator tmpg_checker u_tmpg_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the text mode pixel generator with its own pixel predictor
module testbench;
   import tmpg_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int TEXT_W = CELL_COLUMNS * CELL_W;
   localparam int TEXT_H = CELL_ROWS * CELL_H;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  store_index;
      logic [15:0] data_word;
      logic [7:0]  pixel_x;
      logic [6:0]  pixel_y;
   } req_item_type;

   typedef struct packed {
      logic [COLOR_W-1:0] pixel_color;
      logic               in_border;
   } pixel_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_mode;
   logic [7:0]             req_store_index;
   logic [15:0]            req_data_word;
   logic [7:0]             req_pixel_x;
   logic [6:0]             req_pixel_y;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [23:0]            rsp_pixel_color;
   logic                   rsp_in_border;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   req_item_type           cur_item = '0;
   logic                   req_taken = 1'b0;

   // predictor state
   logic [PAL_W-1:0]       palette_copy [PAL_DEPTH];
   logic [GLYPH_W-1:0]     glyph_copy [GLYPH_DEPTH];
   cfg_type                cfg = '0;

   // which store entries the queued loads write, marked when each load is queued
   bit                     palette_loaded [PAL_DEPTH];
   bit                     glyph_loaded [GLYPH_DEPTH];

   req_item_type           req_items [$];
   pixel_type              pixels_due [$];
   pixel_type              want;

   int send_gap_pct = 0;
   int recv_stall_pct = 0;
   int err_count = 0;
   int n_queued = 0;
   int n_render = 0;
   int n_border = 0;
   int n_blink = 0;
   int n_load = 0;

   assign req_mode        = cur_item.mode;
   assign req_store_index = cur_item.store_index;
   assign req_data_word   = cur_item.data_word;
   assign req_pixel_x     = cur_item.pixel_x;
   assign req_pixel_y     = cur_item.pixel_y;

   text_mode_pixel_generator DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_store_index (req_store_index),
      .req_data_word   (req_data_word),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_in_border   (rsp_in_border),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit in_text(input logic [7:0] px, input logic [6:0] py);
      return px >= BORDER_WIDTH && px < BORDER_WIDTH + TEXT_W &&
             py >= BORDER_WIDTH && py < BORDER_WIDTH + TEXT_H;
   endfunction

   function automatic logic [7:0] glyph_addr(input logic [7:0] px, input logic [15:0] word);
      return 8'((word[6:0] % GLYPH_COUNT) * 2 + ((px - BORDER_WIDTH) % CELL_W) / 2);
   endfunction

   function automatic logic [COLOR_W-1:0] palette_color(input logic [3:0] idx);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      if (cfg.use_loaded) begin
         r = palette_copy[idx][11:8] * 8'd17;
         g = palette_copy[idx][7:4] * 8'd17;
         b = palette_copy[idx][3:0] * 8'd17;
      end else begin
         r = idx[2] ? CH_HI : 8'd0;
         g = idx[1] ? CH_HI : 8'd0;
         b = idx[0] ? CH_HI : 8'd0;
         if (idx == IDX_BROWN) begin
            g = g - CH_STEP;
         end else if (idx[3]) begin
            r = r + CH_STEP;
            g = g + CH_STEP;
            b = b + CH_STEP;
         end
      end
      return {r, g, b};
   endfunction

   // updates the store copies and queues the pixel a render transfer produces
   function automatic void apply_item(input req_item_type it);
      logic [GLYPH_W-1:0] gword;
      logic [7:0]         row_bits;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      pixel_type          pix;
      case (it.mode)
         MODE_PALETTE: begin
            if (it.store_index < PAL_DEPTH) begin
               palette_copy[it.store_index[3:0]] = it.data_word[PAL_W-1:0];
               n_load++;
            end
         end
         MODE_GLYPH: begin
            glyph_copy[it.store_index] = it.data_word;
            n_load++;
         end
         MODE_RENDER: begin
            n_render++;
            if (!in_text(it.pixel_x, it.pixel_y)) begin
               pix.pixel_color = palette_color(cfg.border_idx);
               pix.in_border = 1'b1;
               n_border++;
            end else begin
               gword = glyph_copy[glyph_addr(it.pixel_x, it.data_word)];
               row_bits = (((it.pixel_x - BORDER_WIDTH) % CELL_W) % 2) ? gword[7:0]
                                                                          : gword[15:8];
               fg = palette_color(it.data_word[15:12]);
               bg = palette_color(it.data_word[11:8]);
               if (it.data_word[7] && cfg.blink_phase) begin
                  fg = bg;
                  n_blink++;
               end
               pix.pixel_color = row_bits[(it.pixel_y - BORDER_WIDTH) % CELL_H] ? fg : bg;
               pix.in_border = 1'b0;
            end
            pixels_due.push_back(pix);
         end
         default: ;
      endcase
   endfunction

   function automatic void queue_item(input logic [1:0] mode, input logic [7:0] sidx,
                                      input logic [15:0] word, input logic [7:0] px,
                                      input logic [6:0] py);
      req_item_type it;
      it.mode = mode;
      it.store_index = sidx;
      it.data_word = word;
      it.pixel_x = px;
      it.pixel_y = py;
      req_items.push_back(it);
      n_queued++;
      if (mode == MODE_PALETTE && sidx < PAL_DEPTH) begin
         palette_loaded[sidx[3:0]] = 1'b1;
      end else if (mode == MODE_GLYPH) begin
         glyph_loaded[sidx] = 1'b1;
      end
   endfunction

   // loads any store entry the pixel would read and no earlier load covers, before the render itself
   function automatic void queue_render(input logic [7:0] px, input logic [6:0] py,
                                        input logic [15:0] word);
      logic [7:0] addr;
      logic [3:0] idx;
      bit         txt;
      txt = in_text(px, py);
      addr = glyph_addr(px, word);
      if (txt && !glyph_loaded[addr]) begin
         queue_item(MODE_GLYPH, addr, 16'($urandom), 8'($urandom), 7'($urandom));
      end
      for (int k = 0; k < 3; k++) begin
         idx = (k == 0) ? cfg.border_idx : (k == 1) ? word[15:12] : word[11:8];
         if (cfg.use_loaded && ((k == 0) == !txt) && !palette_loaded[idx]) begin
            queue_item(MODE_PALETTE, 8'(idx), 16'($urandom), 8'($urandom), 7'($urandom));
         end
      end
      queue_item(MODE_RENDER, 8'($urandom), word, px, py);
   endfunction

   function automatic void queue_random_item();
      int         roll;
      logic [7:0] px;
      logic [6:0] py;
      roll = $urandom_range(99);
      if (roll < 55) begin
         if ($urandom_range(99) < 75) begin
            px = 8'($urandom_range(BORDER_WIDTH + TEXT_W - 1, BORDER_WIDTH));
            py = 7'($urandom_range(BORDER_WIDTH + TEXT_H - 1, BORDER_WIDTH));
         end else begin
            px = 8'($urandom);
            py = 7'($urandom);
         end
         queue_render(px, py, 16'($urandom));
      end else if (roll < 75) begin
         queue_item(MODE_GLYPH, 8'($urandom), 16'($urandom), 8'($urandom), 7'($urandom));
      end else if (roll < 93) begin
         px = ($urandom_range(99) < 85) ? 8'($urandom_range(PAL_DEPTH - 1)) : 8'($urandom);
         queue_item(MODE_PALETTE, px, 16'($urandom), 8'($urandom), 7'($urandom));
      end else begin
         queue_item(MODE_UNUSED, 8'($urandom), 16'($urandom), 8'($urandom), 7'($urandom));
      end
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_USE_LOADED:   cfg.use_loaded = value[0];
         CSR_BORDER_INDEX: cfg.border_idx = value[PAL_IDX_W-1:0];
         CSR_BLINK_PHASE:  cfg.blink_phase = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stimulus holds off until every item is sent and every pixel has come back, then lets loads settle
   task automatic wait_idle();
      while (req_items.size() != 0 || req_valid || pixels_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!reset && (req_taken || !req_valid)) begin
         if (req_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            cur_item <= req_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pixels_due.size() == 0) begin
               $error("result transfer with no pixel expected");
               err_count++;
            end else begin
               want = pixels_due.pop_front();
               if (rsp_pixel_color !== want.pixel_color) begin
                  $error("pixel_color: expected %06h, got %06h",
                         want.pixel_color, rsp_pixel_color);
                  err_count++;
               end
               if (rsp_in_border !== want.in_border) begin
                  $error("in_border: expected %0b, got %0b", want.in_border, rsp_in_border);
                  err_count++;
               end
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) apply_item(cur_item);
      end
   end

   initial begin : stimulus
      int         target;
      logic       ul;
      logic       bp;
      logic [3:0] bi;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_gap_pct = 15;
      recv_stall_pct = 67;

      // field extremes and corner cases under reset settings
      queue_item(MODE_PALETTE, 8'd0, 16'hFFFF, 8'd0, 7'd0);
      queue_item(MODE_PALETTE, 8'd15, 16'h0000, 8'hFF, 7'h7F);
      queue_item(MODE_PALETTE, 8'd16, 16'hABCD, 8'h55, 7'h2A);
      queue_item(MODE_PALETTE, 8'hFF, 16'hFFFF, 8'hAA, 7'h55);
      queue_item(MODE_GLYPH, 8'hFF, 16'hFFFF, 8'd0, 7'd0);
      queue_item(MODE_GLYPH, 8'h00, 16'h8001, 8'hFF, 7'h7F);
      queue_item(MODE_UNUSED, 8'hFF, 16'hFFFF, 8'hFF, 7'h7F);
      queue_item(MODE_UNUSED, 8'h00, 16'h0000, 8'h00, 7'h00);
      queue_render(8'd0, 7'd0, 16'h0000);
      queue_render(8'hFF, 7'h7F, 16'hFFFF);
      queue_render(8'd15, 7'd16, 16'h1234);
      queue_render(8'd16, 7'd15, 16'h4321);
      queue_render(8'd16, 7'd16, 16'hF000);
      queue_render(8'd17, 7'd23, 16'h0F00);
      queue_render(8'd143, 7'd111, 16'hFF7F);
      queue_render(8'd144, 7'd111, 16'h9A7F);
      queue_render(8'd143, 7'd112, 16'h6E7F);
      queue_render(8'd159, 7'd127, 16'h5555);
      queue_render(8'd20, 7'd20, 16'h12FF);
      wait_idle();

      for (int ph = 1; ph <= 6; ph++) begin
         case (ph)
            1: begin ul = 1'b1; bi = 4'd15; bp = 1'b1; end
            2: begin ul = 1'b0; bi = 4'd15; bp = 1'b0; end
            3: begin ul = 1'b1; bi = 4'd0;  bp = 1'b0; end
            4: begin ul = 1'b0; bi = 4'd0;  bp = 1'b1; end
            default: begin
               ul = 1'($urandom);
               bi = 4'($urandom);
               bp = 1'($urandom);
            end
         endcase
         write_csr(CSR_USE_LOADED, {3'($urandom), ul});
         write_csr(CSR_BORDER_INDEX, bi);
         write_csr(CSR_BLINK_PHASE, {3'($urandom), bp});
         if (ph == 3) begin
            send_gap_pct = 67;
            recv_stall_pct = 15;
         end else if (ph == 5) begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
         end
         target = n_queued + 105;
         while (n_queued < target) queue_random_item();
         wait_idle();
      end

      repeat (10) @(posedge clock);
      $display("covered %0d renders (%0d border, %0d blinking) and %0d store loads",
               n_render, n_border, n_blink, n_load);
      $display("across 7 register settings with sender and receiver stalls");
      if (err_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
